/* hdl/hsv_to_rgb_converter_defines.svh */
// Assertion macros for the HSV to RGB converter.
// No dependencies; included by files that carry concurrent checks.
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define HSV2RGB_ASSERT_IMP(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("hsv2rgb check failed");
// Next-cycle implication, disabled during reset.
`define HSV2RGB_ASSERT_NEXT(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("hsv2rgb check failed");
`else
`define HSV2RGB_ASSERT_IMP(name, ck, rn, ante, cons)
`define HSV2RGB_ASSERT_NEXT(name, ck, rn, ante, cons)
`endif

`endif

/* hdl/hsv2rgb_pkg.sv */
// Shared types and constants for the HSV to RGB converter.
// No dependencies.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

	localparam int FRAC_BITS = 16;
	localparam int HUE_W     = FRAC_BITS;
	localparam int UNIT_W    = FRAC_BITS + 1;   // Q1.F, holds 0..1.0
	localparam int CH_W      = 16;
	localparam int BBF_W     = CH_W + FRAC_BITS; // maximum * brightness, Q16.F

	localparam logic [UNIT_W-1:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

	// Hue sector, one sixth of the circle each.
	typedef enum logic [2:0] {
		SEC_RED_YELLOW    = 3'd0,
		SEC_YELLOW_GREEN  = 3'd1,
		SEC_GREEN_CYAN    = 3'd2,
		SEC_CYAN_BLUE     = 3'd3,
		SEC_BLUE_MAGENTA  = 3'd4,
		SEC_MAGENTA_RED   = 3'd5
	} sector_t;

	typedef struct packed {
		sector_t                sector;
		logic [FRAC_BITS-1:0]   frac;
		logic [UNIT_W-1:0]      sat;
		logic [BBF_W-1:0]       bbfix;
	} prep_t;

	typedef struct packed {
		sector_t                sector;
		logic [BBF_W-1:0]       bbfix;
		logic [UNIT_W-1:0]      sf;
		logic [UNIT_W-1:0]      sg;
		logic [CH_W-1:0]        p;
	} terms_t;

	typedef struct packed {
		sector_t                sector;
		logic [CH_W-1:0]        bb;
		logic [CH_W-1:0]        p;
		logic [CH_W-1:0]        q;
		logic [CH_W-1:0]        t;
	} chan_t;

	typedef struct packed {
		logic [CH_W-1:0]        red;
		logic [CH_W-1:0]        green;
		logic [CH_W-1:0]        blue;
	} rgb_t;

endpackage

/* hdl/hsv2rgb_if.sv */
// Valid/ready channel interfaces: HSV pixel in, RGB pixel out, config write.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

interface hsv2rgb_hsv_if;
	import hsv2rgb_pkg::*;
	logic              valid;
	logic              ready;
	logic [HUE_W-1:0]  hue;
	logic [UNIT_W-1:0] saturation;
	logic [UNIT_W-1:0] brightness;
	modport source (output valid, hue, saturation, brightness, input ready);
	modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_rgb_if;
	import hsv2rgb_pkg::*;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;
	modport source (output valid, red, green, blue, input ready);
	modport sink   (input valid, red, green, blue, output ready);
endinterface

interface hsv2rgb_cfg_if;
	import hsv2rgb_pkg::*;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] channel_maximum;
	modport source (output valid, channel_maximum, input ready);
	modport sink   (input valid, channel_maximum, output ready);
endinterface

/* hdl/hsv2rgb_prep.sv */
// Stage 1: hue wrap and sector split, saturation and brightness clamps, maximum * brightness.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_prep (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [hsv2rgb_pkg::HUE_W-1:0]     hue,
	input  logic [hsv2rgb_pkg::UNIT_W-1:0]    saturation,
	input  logic [hsv2rgb_pkg::UNIT_W-1:0]    brightness,
	input  logic [hsv2rgb_pkg::CH_W-1:0]      channel_maximum,
	output logic                              out_valid,
	input  logic                              out_ready,
	output hsv2rgb_pkg::prep_t                out_data
);
	import hsv2rgb_pkg::*;

	logic [FRAC_BITS+2:0] h6;
	logic [UNIT_W-1:0]    sat_c;
	logic [UNIT_W-1:0]    val_c;
	logic [BBF_W:0]       bb_prod;
	prep_t                nxt;
	logic                 valid_s1;
	prep_t                data_s1;

	// hue * 6 as 4h + 2h
	assign h6      = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
	assign sat_c   = (saturation > ONE_FX) ? ONE_FX : saturation;
	assign val_c   = (brightness > ONE_FX) ? ONE_FX : brightness;
	assign bb_prod = channel_maximum * val_c;

	assign nxt.sector = sector_t'(h6[FRAC_BITS+2:FRAC_BITS]);
	assign nxt.frac   = h6[FRAC_BITS-1:0];
	assign nxt.sat    = sat_c;
	assign nxt.bbfix  = bb_prod[BBF_W-1:0];

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

/* hdl/hsv2rgb_terms.sv */
// Stage 2: S*f, S*(1-f) and the p channel.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_terms (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  hsv2rgb_pkg::prep_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output hsv2rgb_pkg::terms_t out_data
);
	import hsv2rgb_pkg::*;

	logic [UNIT_W-1:0]          omf;
	logic [UNIT_W-1:0]          oms;
	logic [2*FRAC_BITS:0]       sf_prod;
	logic [2*FRAC_BITS:0]       sg_prod;
	logic [BBF_W+FRAC_BITS:0]   p_prod;
	terms_t                     nxt;
	logic                       valid_s2;
	terms_t                     data_s2;

	assign omf     = ONE_FX - {1'b0, in_data.frac};
	assign oms     = ONE_FX - in_data.sat;
	assign sf_prod = in_data.sat * in_data.frac;
	assign sg_prod = in_data.sat * omf;
	assign p_prod  = in_data.bbfix * oms;

	assign nxt.sector = in_data.sector;
	assign nxt.bbfix  = in_data.bbfix;
	assign nxt.sf     = sf_prod[2*FRAC_BITS:FRAC_BITS];
	assign nxt.sg     = sg_prod[2*FRAC_BITS:FRAC_BITS];
	assign nxt.p      = p_prod[2*FRAC_BITS+CH_W-1:2*FRAC_BITS];

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s2 <= nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

/* hdl/hsv2rgb_scale.sv */
// Stage 3: q and t channels, brightness full scale.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_scale (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hsv2rgb_pkg::terms_t in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output hsv2rgb_pkg::chan_t  out_data
);
	import hsv2rgb_pkg::*;

	logic [UNIT_W-1:0]          omq;
	logic [UNIT_W-1:0]          omt;
	logic [BBF_W+FRAC_BITS:0]   q_prod;
	logic [BBF_W+FRAC_BITS:0]   t_prod;
	chan_t                      nxt;
	logic                       valid_s3;
	chan_t                      data_s3;

	assign omq    = ONE_FX - in_data.sf;
	assign omt    = ONE_FX - in_data.sg;
	assign q_prod = in_data.bbfix * omq;
	assign t_prod = in_data.bbfix * omt;

	assign nxt.sector = in_data.sector;
	assign nxt.bb     = in_data.bbfix[BBF_W-1:FRAC_BITS];
	assign nxt.p      = in_data.p;
	assign nxt.q      = q_prod[2*FRAC_BITS+CH_W-1:2*FRAC_BITS];
	assign nxt.t      = t_prod[2*FRAC_BITS+CH_W-1:2*FRAC_BITS];

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s3 <= nxt;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

/* hdl/hsv2rgb_mux.sv */
// Stage 4: per-sector channel assignment into the output register.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_mux (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  hsv2rgb_pkg::chan_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output hsv2rgb_pkg::rgb_t  out_data
);
	import hsv2rgb_pkg::*;

	rgb_t nxt;
	logic valid_s4;
	rgb_t data_s4;

	always_comb begin
		case (in_data.sector)
			SEC_RED_YELLOW: begin
				nxt = '{red: in_data.bb, green: in_data.t, blue: in_data.p};
			end
			SEC_YELLOW_GREEN: begin
				nxt = '{red: in_data.q, green: in_data.bb, blue: in_data.p};
			end
			SEC_GREEN_CYAN: begin
				nxt = '{red: in_data.p, green: in_data.bb, blue: in_data.t};
			end
			SEC_CYAN_BLUE: begin
				nxt = '{red: in_data.p, green: in_data.q, blue: in_data.bb};
			end
			SEC_BLUE_MAGENTA: begin
				nxt = '{red: in_data.t, green: in_data.p, blue: in_data.bb};
			end
			default: begin
				nxt = '{red: in_data.bb, green: in_data.p, blue: in_data.q};
			end
		endcase
	end

	assign in_ready = !valid_s4 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (in_ready) begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s4 <= nxt;
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = data_s4;

endmodule

/* hdl/hsv_to_rgb_converter.sv */
// HSV to RGB converter, top level; depends on hsv2rgb_pkg, the channel
// interfaces, the four stage modules and hsv_to_rgb_converter_defines.svh.
// Takes one hue/saturation/brightness pixel per clock unless back-pressure
// from rgb fills the pipeline, and returns red, green and blue scaled so
// that brightness 1.0 maps to channel_maximum (reset 255). Hue is a Q0.16
// fraction of the circle and wraps; saturation and brightness are Q1.16 and
// clamp to 1.0 when above it. Each pixel passes in order through the four
// register stages (clamp and maximum*brightness; S*f, S*(1-f) and p; q and
// t; channel select), and the block can take a new pixel while earlier ones
// are still in flight; each stage holds at most one multiply between
// registers. Each stage advances when its successor is empty or moving, so a
// stall on rgb fills bubbles first and only then drops hsv.ready, which is a
// combinational function of rgb.ready. Write channel_maximum only while the
// pipeline is empty; cfg.ready is always high.
`timescale 1ns / 1ps
`include "hsv_to_rgb_converter_defines.svh"

module hsv_to_rgb_converter (
	input  logic             clk,
	input  logic             arst_n,
	hsv2rgb_hsv_if.sink      hsv,
	hsv2rgb_rgb_if.source    rgb,
	hsv2rgb_cfg_if.sink      cfg
);
	import hsv2rgb_pkg::*;

	logic [CH_W-1:0] channel_maximum_q;

	logic   v_s1, v_s2, v_s3;
	logic   rdy_s2, rdy_s3, rdy_s4;
	prep_t  prep_s1;
	terms_t terms_s2;
	chan_t  chan_s3;
	rgb_t   rgb_s4;

	// Config register: always take the write.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_maximum_q <= CH_W'(255);
		end else if (cfg.valid) begin
			channel_maximum_q <= cfg.channel_maximum;
		end
	end

	// Clamp inputs, split hue into sector and fraction, form maximum*brightness.
	hsv2rgb_prep u_prep (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (hsv.valid),
		.in_ready        (hsv.ready),
		.hue             (hsv.hue),
		.saturation      (hsv.saturation),
		.brightness      (hsv.brightness),
		.channel_maximum (channel_maximum_q),
		.out_valid       (v_s1),
		.out_ready       (rdy_s2),
		.out_data        (prep_s1)
	);

	// Saturation terms and the p channel.
	hsv2rgb_terms u_terms (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (rdy_s2),
		.in_data   (prep_s1),
		.out_valid (v_s2),
		.out_ready (rdy_s3),
		.out_data  (terms_s2)
	);

	// q and t channels.
	hsv2rgb_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (rdy_s3),
		.in_data   (terms_s2),
		.out_valid (v_s3),
		.out_ready (rdy_s4),
		.out_data  (chan_s3)
	);

	// Route channels by sector into the output register.
	hsv2rgb_mux u_mux (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (rdy_s4),
		.in_data   (chan_s3),
		.out_valid (rgb.valid),
		.out_ready (rgb.ready),
		.out_data  (rgb_s4)
	);

	assign rgb.red   = rgb_s4.red;
	assign rgb.green = rgb_s4.green;
	assign rgb.blue  = rgb_s4.blue;

	// Sector from hue*6 must stay below six.
	`HSV2RGB_ASSERT_IMP(a_sector_range, clk, arst_n, v_s1, prep_s1.sector <= SEC_MAGENTA_RED)
	// p, q and t never exceed the full-brightness channel.
	`HSV2RGB_ASSERT_IMP(a_chan_bound, clk, arst_n, v_s3, (chan_s3.p <= chan_s3.bb) && (chan_s3.q <= chan_s3.bb) && (chan_s3.t <= chan_s3.bb))
	// Input back-pressure only when every stage is full and the output stalls.
	`HSV2RGB_ASSERT_IMP(a_full_stall, clk, arst_n, !hsv.ready, v_s1 && v_s2 && v_s3 && rgb.valid && !rgb.ready)
	// An accepted pixel lands in stage 1.
	`HSV2RGB_ASSERT_NEXT(a_enter_s1, clk, arst_n, hsv.valid && hsv.ready, v_s1)

endmodule
